[design/twssm_pkg.sv]
// Shared types and constants of the three-wire sensor serial master.
`default_nettype none

package twssm_pkg;

    // Operation codes carried in the operation field of an input word.
    typedef logic [1:0] op_t;
    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_WRITE = 2'd2;
    localparam op_t OP_BURST = 2'd3;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_TICKS_PER_US = 2'd0;
    localparam cfg_index_t CFG_BYTE_GAP_US  = 2'd1;
    localparam cfg_index_t CFG_BURST_ADDR   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] TICKS_PER_US_RST = 8'd48;
    localparam logic [7:0] BYTE_GAP_US_RST  = 8'd22;
    localparam logic [6:0] BURST_ADDR_RST   = 7'd99;

    // Bit 7 of the first byte marks a register write.
    localparam logic [7:0] WRITE_FLAG = 8'h80;

    // Word widths on the stream ports.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Bit positions in the result word.
    localparam int OUT_CS_BIT    = 0;
    localparam int OUT_SCLK_BIT  = 1;
    localparam int OUT_DOUT_BIT  = 2;
    localparam int OUT_DRIVE_BIT = 3;
    localparam int OUT_BUSY_BIT  = 4;
    localparam int OUT_DONE_BIT  = 5;

endpackage

`default_nettype wire

[design/three_wire_sensor_serial_master.sv]
// Top level of the tick-driven three-wire sensor serial master.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    one bus tick with optional command
//  m_axis    out        m_axis_tvalid/m_axis_tready    bus levels and status after the tick
//  cfg       in         cfg_valid/cfg_ready            register index and write data
//
// Every input word is one tick of the bus timer and produces exactly one result word.
// The whole tick update is combinational between the sequencer state registers
// and the result register, so one word is taken per cycle while the result side keeps up.
// The result register decouples the two sides: a new word is accepted whenever the
// result register is empty or its word is being taken in the same cycle.
// rst_n clears the sequencer to idle, empties the result register and restores the
// configuration registers to their default values. Configuration writes are always taken.
`default_nettype none

module three_wire_sensor_serial_master
    import twssm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input word, from bit 0 up: operation[1:0], address[8:2], write_data[16:9],
    // sdio_in[17], zero fill [23:18].
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result word, from bit 0 up: chip_select_n[0], serial_clock[1], sdio_out[2],
    // sdio_drive[3], busy_res[4], done_res[5], read_byte[13:6], delta_x[21:14],
    // delta_y[29:22], motion_seen[30], zero fill [31].
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_data
);

    // Sequencer step codes.
    localparam logic [3:0] STEP_IDLE  = 4'd0;
    localparam logic [3:0] STEP_WLOW  = 4'd1;
    localparam logic [3:0] STEP_WHIGH = 4'd2;
    localparam logic [3:0] STEP_WTAIL = 4'd3;
    localparam logic [3:0] STEP_GAP   = 4'd4;
    localparam logic [3:0] STEP_RLOW  = 4'd5;
    localparam logic [3:0] STEP_RHIGH = 4'd6;

    // Fixed phase lengths in microseconds.
    localparam logic [7:0] WLOW_US  = 8'd2;
    localparam logic [7:0] WTAIL_US = 8'd4;
    localparam logic [7:0] PHASE_US = 8'd1;

    // Input word fields.
    op_t        in_op;
    logic [6:0] in_addr;
    logic [7:0] in_wdata;
    logic       in_sdio;

    assign in_op    = op_t'(s_axis_tdata[1:0]);
    assign in_addr  = s_axis_tdata[8:2];
    assign in_wdata = s_axis_tdata[16:9];
    assign in_sdio  = s_axis_tdata[17];

    // Configuration registers.
    logic [7:0] ticks_per_us_reg;
    logic [7:0] byte_gap_us_reg;
    logic [6:0] burst_addr_reg;

    // Sequencer state.
    logic [3:0] step_reg,         step_next;
    op_t        kind_reg,         kind_next;
    logic [3:0] bit_index_reg,    bit_index_next;
    logic [7:0] tick_count_reg,   tick_count_next;
    logic [7:0] us_count_reg,     us_count_next;
    logic [7:0] shifter_reg,      shifter_next;
    logic [7:0] held_data_reg,    held_data_next;
    logic [1:0] byte_index_reg,   byte_index_next;
    logic [7:0] burst_motion_reg, burst_motion_next;
    logic [7:0] dy_reg,           dy_next;
    logic [7:0] dx_reg,           dx_next;
    logic [7:0] last_read_reg,    last_read_next;

    // Result register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic s_accept;
    logic [7:0] tick_limit;
    logic [7:0] phase_len;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A zero tick count is taken as one tick per microsecond.
    assign tick_limit = (ticks_per_us_reg == 8'd0) ? 8'd1 : ticks_per_us_reg;

    always_comb
    begin
        unique case (step_reg)
            STEP_WLOW:  phase_len = WLOW_US;
            STEP_WTAIL: phase_len = WTAIL_US;
            STEP_GAP:   phase_len = byte_gap_us_reg;
            default:    phase_len = PHASE_US;
        endcase
    end

    // One tick of the sequencer. The gap and byte start are resolved after the
    // phase transition so that a zero gap moves straight on to the next byte or to idle.
    always_comb
    begin
        logic       gap_enter;
        logic       gap_end;
        logic       byte_start;
        logic       done;
        logic       written;
        logic [1:0] last_byte;
        logic       cs_n;
        logic       sclk;
        logic       dout;
        logic       drive;
        logic [7:0] dx_out;
        logic [7:0] dy_out;

        step_next         = step_reg;
        kind_next         = kind_reg;
        bit_index_next    = bit_index_reg;
        tick_count_next   = tick_count_reg;
        us_count_next     = us_count_reg;
        shifter_next      = shifter_reg;
        held_data_next    = held_data_reg;
        byte_index_next   = byte_index_reg;
        burst_motion_next = burst_motion_reg;
        dy_next           = dy_reg;
        dx_next           = dx_reg;
        last_read_next    = last_read_reg;
        gap_enter         = 1'b0;
        gap_end           = 1'b0;
        byte_start        = 1'b0;
        done              = 1'b0;

        if (step_reg != STEP_IDLE)
        begin
            tick_count_next = tick_count_reg + 8'd1;
            if (tick_count_next >= tick_limit)
            begin
                tick_count_next = 8'd0;
                us_count_next   = us_count_reg + 8'd1;
                if (us_count_next >= phase_len)
                begin
                    us_count_next = 8'd0;
                    unique case (step_reg)
                        STEP_WLOW:
                        begin
                            step_next = STEP_WHIGH;
                        end
                        STEP_WHIGH:
                        begin
                            shifter_next   = {shifter_reg[6:0], shifter_reg[7]};
                            bit_index_next = bit_index_reg + 4'd1;
                            step_next      = (bit_index_next >= 4'd8) ? STEP_WTAIL : STEP_WLOW;
                        end
                        STEP_WTAIL:
                        begin
                            gap_enter = 1'b1;
                        end
                        STEP_RLOW:
                        begin
                            shifter_next = {shifter_reg[6:0], in_sdio};
                            step_next    = STEP_RHIGH;
                        end
                        STEP_RHIGH:
                        begin
                            bit_index_next = bit_index_reg + 4'd1;
                            if (bit_index_next >= 4'd8)
                            begin
                                if (kind_reg == OP_BURST)
                                begin
                                    unique case (byte_index_reg)
                                        2'd1:    burst_motion_next = shifter_reg;
                                        2'd2:    dy_next           = shifter_reg;
                                        2'd3:    dx_next           = shifter_reg;
                                        default: burst_motion_next = burst_motion_reg;
                                    endcase
                                end
                                else
                                begin
                                    last_read_next = shifter_reg;
                                end
                                gap_enter = 1'b1;
                            end
                            else
                            begin
                                step_next = STEP_RLOW;
                            end
                        end
                        STEP_GAP:
                        begin
                            gap_end = 1'b1;
                        end
                        default:
                        begin
                            step_next = STEP_IDLE;
                        end
                    endcase
                end
            end
        end
        else if (in_op != OP_TICK)
        begin
            kind_next       = in_op;
            byte_index_next = 2'd0;
            held_data_next  = in_wdata;
            unique case (in_op)
                OP_WRITE: shifter_next = WRITE_FLAG | {1'b0, in_addr};
                OP_READ:  shifter_next = {1'b0, in_addr};
                default:  shifter_next = {1'b0, burst_addr_reg};
            endcase
            byte_start = 1'b1;
        end

        if (gap_enter)
        begin
            step_next       = STEP_GAP;
            tick_count_next = 8'd0;
            us_count_next   = 8'd0;
            if (byte_gap_us_reg == 8'd0)
            begin
                gap_end = 1'b1;
            end
        end

        last_byte = (kind_next == OP_BURST) ? 2'd3 : 2'd1;
        if (gap_end)
        begin
            if (byte_index_next >= last_byte)
            begin
                step_next       = STEP_IDLE;
                tick_count_next = 8'd0;
                us_count_next   = 8'd0;
                done            = 1'b1;
            end
            else
            begin
                byte_index_next = byte_index_next + 2'd1;
                byte_start      = 1'b1;
            end
        end

        // The address byte and the data byte of a write are driven; all others are read.
        written = (byte_index_next == 2'd0) ||
                  (kind_next == OP_WRITE && byte_index_next == 2'd1);
        if (byte_start)
        begin
            bit_index_next  = 4'd0;
            tick_count_next = 8'd0;
            us_count_next   = 8'd0;
            if (written)
            begin
                if (byte_index_next != 2'd0)
                begin
                    shifter_next = held_data_next;
                end
                step_next = STEP_WLOW;
            end
            else
            begin
                shifter_next = 8'd0;
                step_next    = STEP_RLOW;
            end
        end

        // Bus levels for the coming tick.
        cs_n  = (step_next == STEP_IDLE);
        sclk  = 1'b1;
        dout  = 1'b0;
        drive = 1'b0;
        unique case (step_next)
            STEP_WLOW:
            begin
                sclk  = 1'b0;
                drive = 1'b1;
                dout  = shifter_next[7];
            end
            STEP_WHIGH:
            begin
                drive = 1'b1;
                dout  = shifter_next[7];
            end
            STEP_WTAIL:
            begin
                drive = 1'b1;
                dout  = shifter_next[0];
            end
            STEP_GAP:
            begin
                // After a written byte the line stays at its last bit.
                drive = written;
                dout  = written && shifter_next[0];
            end
            STEP_RLOW:
            begin
                sclk = 1'b0;
            end
            default:
            begin
                sclk = 1'b1;
            end
        endcase

        dx_out = burst_motion_next[7] ? dx_next : 8'd0;
        dy_out = burst_motion_next[7] ? dy_next : 8'd0;

        out_data_next = {1'b0, burst_motion_next[7], dy_out, dx_out, last_read_next,
                         done, !cs_n, drive, dout, sclk, cs_n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg <= TICKS_PER_US_RST;
            byte_gap_us_reg  <= BYTE_GAP_US_RST;
            burst_addr_reg   <= BURST_ADDR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_US: ticks_per_us_reg <= cfg_data;
                CFG_BYTE_GAP_US:  byte_gap_us_reg  <= cfg_data;
                CFG_BURST_ADDR:   burst_addr_reg   <= cfg_data[6:0];
                default:          burst_addr_reg   <= burst_addr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_IDLE;
            kind_reg         <= OP_TICK;
            bit_index_reg    <= 4'd0;
            tick_count_reg   <= 8'd0;
            us_count_reg     <= 8'd0;
            shifter_reg      <= 8'd0;
            held_data_reg    <= 8'd0;
            byte_index_reg   <= 2'd0;
            burst_motion_reg <= 8'd0;
            dy_reg           <= 8'd0;
            dx_reg           <= 8'd0;
            last_read_reg    <= 8'd0;
        end
        else if (s_accept)
        begin
            step_reg         <= step_next;
            kind_reg         <= kind_next;
            bit_index_reg    <= bit_index_next;
            tick_count_reg   <= tick_count_next;
            us_count_reg     <= us_count_next;
            shifter_reg      <= shifter_next;
            held_data_reg    <= held_data_next;
            byte_index_reg   <= byte_index_next;
            burst_motion_reg <= burst_motion_next;
            dy_reg           <= dy_next;
            dx_reg           <= dx_next;
            last_read_reg    <= last_read_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

[design/twssm_checker.sv]
// Port-level checks of the three-wire sensor serial master and their binding.
`default_nettype none

module twssm_port_checks
    import twssm_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // The input side is open exactly when the result register can take a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the result register");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // A finishing transaction leaves the master idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_DONE_BIT] |-> !m_axis_tdata[OUT_BUSY_BIT])
        else $error("done reported while still busy");

    // An idle bus is deselected, clock high and data line released.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_BUSY_BIT] |->
            m_axis_tdata[OUT_CS_BIT] && m_axis_tdata[OUT_SCLK_BIT] &&
            !m_axis_tdata[OUT_DRIVE_BIT] && !m_axis_tdata[OUT_DOUT_BIT])
        else $error("idle bus levels wrong");

    // Chip select is asserted exactly while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_BUSY_BIT] != m_axis_tdata[OUT_CS_BIT])
        else $error("chip select disagrees with busy");

endmodule

bind three_wire_sensor_serial_master twssm_port_checks u_twssm_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
